FILE: rtl/i2t_pkg.sv
package i2t_pkg;

	localparam int CurrentWidth = 16;
	localparam int LevelOutWidth = 8;
	localparam int IntegralWidth = 32;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 20;
	localparam int ShiftWidth = 4;
	localparam int LeakWidth = 20;
	localparam int ThreshWidth = 12;
	localparam int NonlinWidth = 20;

	localparam logic [ShiftWidth-1:0]  LevelShiftReset = 4'd7;
	localparam logic [LeakWidth-1:0]   LeakAmountReset = 20'd3433;
	localparam logic [LeakWidth-1:0]   WarningReset    = 20'd12359;
	localparam logic [LeakWidth-1:0]   LimitReset      = 20'd15449;
	localparam logic [ThreshWidth-1:0] ThreshReset     = 12'd137;
	localparam logic                   NonlinEnReset   = 1'b1;

	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [1:0] {
		STAT_NORMAL  = 2'd0,
		STAT_WARNING = 2'd1,
		STAT_LIMIT   = 2'd2
	} status_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_LEVEL_SHIFT   = 3'd0,
		CFG_LEAK_AMOUNT   = 3'd1,
		CFG_WARNING_LEVEL = 3'd2,
		CFG_LIMIT_LEVEL   = 3'd3,
		CFG_NONLIN_THRESH = 3'd4,
		CFG_NONLIN_ENABLE = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DIV,
		ST_SCALE,
		ST_SQUARE,
		ST_ADD,
		ST_LEAK,
		ST_OUT
	} fsm_state_t;

	typedef struct packed {
		logic                           action;
		logic signed [CurrentWidth-1:0] current;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic [IntegralWidth-1:0]  integral_value;
		logic [LevelOutWidth-1:0]  level;
	} out_item_t;

	typedef struct packed {
		logic acc_clr;
		logic acc_en;
		logic div_en;
		logic scale_en;
		logic sq_en;
	} lc_ctl_t;

endpackage

FILE: rtl/i2t_sample_mem.sv
module i2t_sample_mem #(
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]                  wr_addr,
	input  logic signed [i2t_pkg::CurrentWidth-1:0]   wr_data,
	input  logic                                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]                  rd_addr,
	output logic signed [i2t_pkg::CurrentWidth-1:0]   rd_data
);
	import i2t_pkg::*;

	logic signed [CurrentWidth-1:0] mem [DEPTH];
	logic [DEPTH-1:0]               valid_q;
	logic signed [CurrentWidth-1:0] data_q;
	logic                           hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

FILE: rtl/i2t_level_calc.sv
module i2t_level_calc #(
	parameter int NUM_SAMPLES = 8,
	parameter int LEVEL_MAX = 255
) (
	input  logic                                    clk,
	input  i2t_pkg::lc_ctl_t                        ctl,
	input  logic signed [i2t_pkg::CurrentWidth-1:0] rd_data,
	input  logic [i2t_pkg::ShiftWidth-1:0]          level_shift,
	input  logic [i2t_pkg::ThreshWidth-1:0]         nonlin_threshold,
	input  logic                                    nonlin_enable,
	output logic [$clog2(LEVEL_MAX+1)-1:0]          level,
	output logic [2*$clog2(LEVEL_MAX+1)-1:0]        square
);
	import i2t_pkg::*;

	localparam int L  = $clog2(NUM_SAMPLES);
	localparam int SW = CurrentWidth + L;
	localparam int K  = SW + L;
	localparam int MW = SW + 1;
	localparam int PW = SW + MW;
	localparam int QW = CurrentWidth;
	localparam int LW = $clog2(LEVEL_MAX + 1);
	// Rounded-up reciprocal; exact for every sum below 2^SW.
	localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(NUM_SAMPLES) - 64'd1)
		/ 64'(NUM_SAMPLES);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic [SW-1:0]           acc_q;
	logic [CurrentWidth-1:0] mag;
	logic [PW-1:0]           prod_s1;
	logic [QW-1:0]           quot;
	logic [QW-1:0]           shifted;
	logic [NonlinWidth-1:0]  diff;
	logic [NonlinWidth-1:0]  gained;
	logic [NonlinWidth-1:0]  gain_s2;
	logic [LW-1:0]           sat;
	logic [LW-1:0]           lvl_s3;
	logic [2*LW-1:0]         sq_s3;

	assign mag = rd_data[CurrentWidth-1] ? CurrentWidth'(-rd_data) : CurrentWidth'(rd_data);

	assign quot    = prod_s1[K +: QW];
	assign shifted = quot >> level_shift;
	assign diff    = NonlinWidth'(shifted) - NonlinWidth'(nonlin_threshold);

	always_comb begin
		if (nonlin_enable && (shifted > QW'(nonlin_threshold))) begin
			gained = NonlinWidth'(shifted) + (diff << 3) + (diff << 1);
		end else begin
			gained = NonlinWidth'(shifted);
		end
	end

	assign sat = (gain_s2 > NonlinWidth'(LEVEL_MAX)) ? LW'(LEVEL_MAX) : LW'(gain_s2);

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + SW'(mag);
		end
		if (ctl.div_en) begin
			prod_s1 <= acc_q * RECIP_M;
		end
		if (ctl.scale_en) begin
			gain_s2 <= gained;
		end
		if (ctl.sq_en) begin
			lvl_s3 <= sat;
			sq_s3  <= sat * sat;
		end
	end

	assign level  = lvl_s3;
	assign square = sq_s3;

endmodule

FILE: rtl/i2t_current_limit_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data: action, current
// out     | output    | out_valid/out_stall| out_data: status, integral_value, level
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Sample transactions are taken only in the idle state; a compute transaction occupies the
// block while the single read port of the sample memory is swept one entry per cycle,
// followed by the divide, gain, square and integrator stages. Reset clears control state and
// the per-entry valid bits of the sample memory; there is no clearing pass. Sample
// transactions are taken while a result waits on a stalled output; a finished compute holds
// in its last state until the output register is free.
module i2t_current_limit_unit #(
	parameter int NUM_SAMPLES = 8,
	parameter int DECIMATION = 12,
	parameter int LEVEL_MAX = 255
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  i2t_pkg::in_item_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output i2t_pkg::out_item_t                     out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [i2t_pkg::CfgIndexWidth-1:0]      cfg_index,
	input  logic [i2t_pkg::CfgDataWidth-1:0]       cfg_data
);
	import i2t_pkg::*;

	localparam int AW  = $clog2(NUM_SAMPLES);
	localparam int WIW = $clog2(NUM_SAMPLES + 1);
	localparam int DW  = $clog2(DECIMATION + 1);
	localparam int LW  = $clog2(LEVEL_MAX + 1);

	fsm_state_t state_q, state_d;

	logic [ShiftWidth-1:0]  shift_q;
	logic [LeakWidth-1:0]   leak_q;
	logic [LeakWidth-1:0]   warn_q;
	logic [LeakWidth-1:0]   limit_q;
	logic [ThreshWidth-1:0] thresh_q;
	logic                   nl_en_q;

	logic [DW-1:0]  dec_q;
	logic [DW:0]    dec_inc;
	logic [DW-1:0]  dec_nxt;
	logic [WIW-1:0] widx_q;
	logic [AW-1:0]  rd_addr_q;
	logic           rd_vld_s1;

	logic in_acc, take_sample, take_compute;
	logic mem_wr, rd_en, load_out, last_addr;
	lc_ctl_t ctl;

	logic signed [CurrentWidth-1:0] rd_data;
	logic [LW-1:0]                  level;
	logic [2*LW-1:0]                square;

	logic [IntegralWidth:0]   add_sum;
	logic [IntegralWidth-1:0] add_s1;
	logic [IntegralWidth-1:0] integral_q;
	status_t                  status;
	out_item_t                out_q;
	logic                     out_valid_q;

	assign in_acc       = in_valid && !in_stall;
	assign take_sample  = in_acc && (in_data.action == ACT_SAMPLE);
	assign take_compute = in_acc && (in_data.action == ACT_COMPUTE);
	assign last_addr    = (rd_addr_q == AW'(NUM_SAMPLES - 1));

	assign dec_inc = {1'b0, dec_q} + (DW + 1)'(1);
	assign dec_nxt = (dec_inc >= (DW + 1)'(DECIMATION)) ? '0 : dec_inc[DW-1:0];
	assign mem_wr  = take_sample && (dec_nxt == '0) && (widx_q < WIW'(NUM_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		rd_en        = 1'b0;
		load_out     = 1'b0;
		ctl          = '0;
		ctl.acc_en   = rd_vld_s1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (take_compute) begin
					ctl.acc_clr = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DIV;
			ST_DIV: begin
				ctl.div_en = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				ctl.scale_en = 1'b1;
				state_d      = ST_SQUARE;
			end
			ST_SQUARE: begin
				ctl.sq_en = 1'b1;
				state_d   = ST_ADD;
			end
			ST_ADD: state_d = ST_LEAK;
			ST_LEAK: state_d = ST_OUT;
			ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= LevelShiftReset;
			leak_q   <= LeakAmountReset;
			warn_q   <= WarningReset;
			limit_q  <= LimitReset;
			thresh_q <= ThreshReset;
			nl_en_q  <= NonlinEnReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEVEL_SHIFT:   shift_q  <= cfg_data[ShiftWidth-1:0];
				CFG_LEAK_AMOUNT:   leak_q   <= cfg_data[LeakWidth-1:0];
				CFG_WARNING_LEVEL: warn_q   <= cfg_data[LeakWidth-1:0];
				CFG_LIMIT_LEVEL:   limit_q  <= cfg_data[LeakWidth-1:0];
				CFG_NONLIN_THRESH: thresh_q <= cfg_data[ThreshWidth-1:0];
				CFG_NONLIN_ENABLE: nl_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q       <= DW'(1);
			widx_q      <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			integral_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (take_sample) begin
				dec_q <= dec_nxt;
			end
			if (mem_wr) begin
				widx_q <= widx_q + WIW'(1);
			end else if (take_compute) begin
				widx_q <= '0;
			end
			if (take_compute) begin
				rd_addr_q <= '0;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			// The leak takes the integral to zero when it reaches or exceeds it.
			if (state_q == ST_LEAK) begin
				integral_q <= (add_s1 > IntegralWidth'(leak_q))
					? add_s1 - IntegralWidth'(leak_q) : '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign add_sum = {1'b0, integral_q} + (IntegralWidth + 1)'(square);

	always_comb begin
		if (integral_q < IntegralWidth'(warn_q)) begin
			status = STAT_NORMAL;
		end else if (integral_q < IntegralWidth'(limit_q)) begin
			status = STAT_WARNING;
		end else begin
			status = STAT_LIMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			add_s1 <= add_sum[IntegralWidth] ? '1 : add_sum[IntegralWidth-1:0];
		end
		if (load_out) begin
			out_q.status         <= status;
			out_q.integral_value <= integral_q;
			out_q.level          <= LevelOutWidth'(level);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	i2t_sample_mem #(
		.DEPTH(NUM_SAMPLES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr),
		.wr_addr (widx_q[AW-1:0]),
		.wr_data (in_data.current),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	i2t_level_calc #(
		.NUM_SAMPLES(NUM_SAMPLES),
		.LEVEL_MAX  (LEVEL_MAX)
	) u_level (
		.clk              (clk),
		.ctl              (ctl),
		.rd_data          (rd_data),
		.level_shift      (shift_q),
		.nonlin_threshold (thresh_q),
		.nonlin_enable    (nl_en_q),
		.level            (level),
		.square           (square)
	);

`ifndef SYNTHESIS
	a_widx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= WIW'(NUM_SAMPLES))
		else $error("write index ran past the sample store");

	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> (state_q == ST_IDLE))
		else $error("sample write during a compute sweep");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT))
		else $error("pending result overwritten");

	a_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (square <= (2*LW)'(LEVEL_MAX * LEVEL_MAX)))
		else $error("square above saturated level");

	a_status_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_NORMAL)
			|-> (out_q.integral_value < IntegralWidth'(warn_q)))
		else $error("normal status with integral at warning level");
`endif

endmodule
